>>> rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, held off while reset is high
`define CHK_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that a condition never occurs
`define CHK_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

>>> rtl/core/srob_pkg.sv
`default_nettype none

package srob_pkg;

   // built ring depth, the index width derived from it, and fixed widths
   localparam int DEPTH = 32;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = 6;
   localparam int KEY_W = 32;
   localparam int TAG_W = 32;

   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(32);

   // action codes
   localparam logic [2:0] ACT_PUSH_BACK  = 3'd0;
   localparam logic [2:0] ACT_PUSH_FRONT = 3'd1;
   localparam logic [2:0] ACT_INSERT     = 3'd2;
   localparam logic [2:0] ACT_POP        = 3'd3;
   localparam logic [2:0] ACT_PEEK       = 3'd4;
   localparam logic [2:0] ACT_CLEAR      = 3'd5;

   // status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_DROPPED = 3'd1;
   localparam logic [2:0] ST_FULL    = 3'd2;
   localparam logic [2:0] ST_DUP     = 3'd3;
   localparam logic [2:0] ST_EMPTY   = 3'd4;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic [KEY_W-1:0] seq;
      logic [TAG_W-1:0] tag;
   } entry_type;

   // entry memory access: one write and one read port
   typedef struct packed {
      logic      we;
      idx_type   waddr;
      entry_type wdata;
      idx_type   raddr;
   } mem_req_type;

   // outcome of the shared key compare
   typedef struct packed {
      logic eq;
      logic gt;
   } cmp_type;

   typedef struct packed {
      logic [2:0]       status;
      logic             out_valid;
      logic [KEY_W-1:0] out_seq;
      logic [TAG_W-1:0] out_tag;
      cnt_type          occupancy;
      logic             is_full;
      logic             is_empty;
   } result_type;

   typedef struct packed {
      logic    idle;
      cnt_type count;
      cnt_type cap;
   } ctrl_status_type;

   // capacity in use: zero acts as one, clipped to the built depth
   function automatic cnt_type cap_limit(input cnt_type v);
      if (v == '0) return CNT_W'(1);
      if (v > CNT_W'(DEPTH)) return CNT_W'(DEPTH);
      return v;
   endfunction

   // ring index forward, wrapping at the capacity
   function automatic idx_type step_up(input idx_type i, input cnt_type cap);
      cnt_type nx;
      nx = CNT_W'(i) + CNT_W'(1);
      return (nx >= cap) ? '0 : IDX_W'(nx);
   endfunction

   // ring index backward, wrapping at the capacity
   function automatic idx_type step_down(input idx_type i, input cnt_type cap);
      cnt_type top;
      top = cap - CNT_W'(1);
      return ((i == '0) || (CNT_W'(i) >= cap)) ? IDX_W'(top) : i - IDX_W'(1);
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/srob_cmp.sv
`default_nettype none

// Shared key comparator: stored key against the request key, unsigned
module srob_cmp import srob_pkg::*; (
   input  wire logic [KEY_W-1:0] stored_key,
   input  wire logic [KEY_W-1:0] req_key,
   output cmp_type               result
);

   assign result.eq = (stored_key == req_key);
   assign result.gt = (stored_key > req_key);

endmodule

`default_nettype wire

>>> rtl/core/srob_store.sv
`default_nettype none

// Entry memory: one write port, one registered read port
module srob_store import srob_pkg::*; (
   input  wire logic        clock,
   input  wire mem_req_type mem_req,
   output entry_type        rd_data
);

   entry_type mem_ff [DEPTH];
   entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.waddr] <= mem_req.wdata;
      end
      rd_ff <= mem_ff[mem_req.raddr];
   end

   assign rd_data = rd_ff;

endmodule

`default_nettype wire

>>> rtl/core/srob_ctrl.sv
`default_nettype none

// Sequencer: ring pointers, capacity, and the scan / shift walks
module srob_ctrl import srob_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [2:0]       req_action,
   input  wire entry_type        req_entry,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [CNT_W-1:0] csr_data,
   output mem_req_type           mem_req,
   input  wire entry_type        rd_data,
   input  wire logic             out_free,
   output logic                  res_valid,
   output result_type            res,
   output ctrl_status_type       st
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_FETCH = 5'b00010,
      S_SCAN  = 5'b00100,
      S_SHIFT = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   idx_type          head_ff, head_in;
   idx_type          tail_ff, tail_in;
   cnt_type          count_ff, count_in;
   cnt_type          cap_ff, cap_in;
   logic [2:0]       act_ff, act_in;
   entry_type        ent_ff, ent_in;
   logic [2:0]       status_ff, status_in;
   logic             ov_ff, ov_in;
   entry_type        out_ff, out_in;
   idx_type          rp_ff, rp_in;
   cnt_type          iss_ff, iss_in;
   cnt_type          cmpn_ff, cmpn_in;
   logic             rdv_ff, rdv_in;
   idx_type          cur_ff, cur_in;
   idx_type          nh_ff, nh_in;

   cnt_type          cap_use;
   logic             full_now;
   logic             req_fire;
   logic             csr_fire;
   logic             stop;
   logic             issue;
   cmp_type          cmp;

   assign cap_use   = cap_limit(cap_ff);
   assign full_now  = (count_ff >= cap_use);
   assign req_ready = (state_ff == S_IDLE);
   // a request offered in the same cycle goes first
   assign csr_ready = (state_ff == S_IDLE) && !req_valid;
   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;

   // one comparator serves both the duplicate scan and the shift walk
   srob_cmp u_cmp (
      .stored_key (rd_data.seq),
      .req_key    (ent_ff.seq),
      .result     (cmp)
   );

   // next-state and datapath control
   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      cap_in    = cap_ff;
      act_in    = act_ff;
      ent_in    = ent_ff;
      status_in = status_ff;
      ov_in     = ov_ff;
      out_in    = out_ff;
      rp_in     = rp_ff;
      iss_in    = iss_ff;
      cmpn_in   = cmpn_ff;
      rdv_in    = 1'b0;
      cur_in    = cur_ff;
      nh_in     = nh_ff;
      stop      = 1'b0;
      issue     = 1'b0;
      res_valid = 1'b0;
      mem_req       = '0;
      mem_req.raddr = head_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               act_in    = req_action;
               ent_in    = req_entry;
               status_in = ST_OK;
               ov_in     = 1'b0;
               out_in    = '0;
               state_in  = S_DONE;
               unique case (req_action)
                  ACT_PUSH_BACK: begin
                     // full: drop the front entry first
                     if (full_now) begin
                        head_in   = step_up(head_ff, cap_use);
                        status_in = ST_DROPPED;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                     end
                     mem_req.we    = 1'b1;
                     mem_req.waddr = tail_ff;
                     mem_req.wdata = req_entry;
                     tail_in       = step_up(tail_ff, cap_use);
                  end
                  ACT_PUSH_FRONT: begin
                     // full: drop the back entry first
                     if (full_now) begin
                        tail_in   = step_down(tail_ff, cap_use);
                        status_in = ST_DROPPED;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                     end
                     head_in       = step_down(head_ff, cap_use);
                     mem_req.we    = 1'b1;
                     mem_req.waddr = step_down(head_ff, cap_use);
                     mem_req.wdata = req_entry;
                  end
                  ACT_INSERT: begin
                     if (full_now) begin
                        status_in = ST_FULL;
                     end else begin
                        state_in = S_SCAN;
                        rp_in    = head_ff;
                        iss_in   = '0;
                        cmpn_in  = '0;
                     end
                  end
                  ACT_POP, ACT_PEEK: begin
                     // read of the front is issued this cycle
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        state_in = S_FETCH;
                     end
                  end
                  ACT_CLEAR: begin
                     head_in  = '0;
                     tail_in  = '0;
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end else if (csr_fire) begin
               // capacity write empties the queue
               cap_in   = csr_data;
               head_in  = '0;
               tail_in  = '0;
               count_in = '0;
            end
         end

         S_FETCH: begin
            ov_in    = 1'b1;
            out_in   = rd_data;
            state_in = S_DONE;
            if (act_ff == ACT_POP) begin
               head_in  = step_up(head_ff, cap_use);
               count_in = count_ff - CNT_W'(1);
            end
         end

         S_SCAN: begin
            // duplicate scan over live entries, reads pipelined ahead
            mem_req.raddr = rp_ff;
            if (rdv_ff) begin
               cmpn_in = cmpn_ff + CNT_W'(1);
               if (cmp.eq) begin
                  status_in = ST_DUP;
                  state_in  = S_DONE;
                  stop      = 1'b1;
               end
            end else if (cmpn_ff == count_ff) begin
               state_in = S_SHIFT;
               cur_in   = step_down(head_ff, cap_use);
               nh_in    = step_down(head_ff, cap_use);
               cmpn_in  = '0;
               stop     = 1'b1;
            end
            issue = !stop && (iss_ff < count_ff);
            if (issue) begin
               rp_in  = step_up(rp_ff, cap_use);
               iss_in = iss_ff + CNT_W'(1);
            end else if (state_in == S_SHIFT) begin
               rp_in  = head_ff;
               iss_in = '0;
            end
            rdv_in = issue;
         end

         S_SHIFT: begin
            // move keys not above the new key one slot toward the front
            mem_req.raddr = rp_ff;
            if (rdv_ff) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = cur_ff;
               if (cmp.gt) begin
                  mem_req.wdata = ent_ff;
                  stop          = 1'b1;
               end else begin
                  mem_req.wdata = rd_data;
                  cur_in        = step_up(cur_ff, cap_use);
                  cmpn_in       = cmpn_ff + CNT_W'(1);
               end
            end else if (cmpn_ff == count_ff) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = cur_ff;
               mem_req.wdata = ent_ff;
               stop          = 1'b1;
            end
            if (stop) begin
               head_in  = nh_ff;
               count_in = count_ff + CNT_W'(1);
               state_in = S_DONE;
            end
            issue = !stop && (iss_ff < count_ff);
            if (issue) begin
               rp_in  = step_up(rp_ff, cap_use);
               iss_in = iss_ff + CNT_W'(1);
            end
            rdv_in = issue;
         end

         S_DONE: begin
            if (out_free) begin
               res_valid = 1'b1;
               state_in  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result as seen after the action
   always_comb begin
      res.status    = status_ff;
      res.out_valid = ov_ff;
      res.out_seq   = out_ff.seq;
      res.out_tag   = out_ff.tag;
      res.occupancy = count_ff;
      res.is_full   = (count_ff == cap_use);
      res.is_empty  = (count_ff == '0);
   end

   assign st.idle  = (state_ff == S_IDLE);
   assign st.count = count_ff;
   assign st.cap   = cap_use;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         cap_ff   <= CAP_RESET;
         rdv_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         cap_ff   <= cap_in;
         rdv_ff   <= rdv_in;
      end
   end

   // payload and walk registers
   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      ent_ff    <= ent_in;
      status_ff <= status_in;
      ov_ff     <= ov_in;
      out_ff    <= out_in;
      rp_ff     <= rp_in;
      iss_ff    <= iss_in;
      cmpn_ff   <= cmpn_in;
      cur_ff    <= cur_in;
      nh_ff     <= nh_in;
   end

endmodule

`default_nettype wire

>>> rtl/core/sorted_deque_reorder_buffer.sv
// Circular deque of (sequence, tag) entries used as a reorder buffer, with
// push back, push front, sorted insert, pop front, peek front and clear.
// One request is worked at a time. Push, clear, unused codes, an insert
// refused as full and a pop or peek on an empty queue go straight to the
// result; a pop or peek of a held entry first waits on one registered read
// of the entry memory. A sorted insert into N held entries makes two passes:
// one pass reads every live entry through the single read port to look for a
// duplicate key, and a second pass moves entries one slot per cycle through
// the same port and the shared key comparator. An insert refused as a
// duplicate ends at the matching entry, within the first pass. The result
// sits in an output register, so a new request is taken while the previous
// result waits. The entry memory has no clearing pass; writing the capacity
// register empties the queue and is taken only when idle with no request
// offered.
`default_nettype none
`include "assert_macros.svh"

module sorted_deque_reorder_buffer import srob_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,  // entry_seq[31:0], entry_tag[63:32]
   input  wire logic [2:0]  req_tuser,  // action[2:0]
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,  // out_seq[31:0], out_tag[63:32],
                                        // occupancy[69:64], is_full[70],
                                        // is_empty[71]
   output logic [3:0]       rsp_tuser,  // status[2:0], out_valid[3]
   // capacity register write
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [5:0]  csr_data
);

   mem_req_type     mem_req;
   entry_type       rd_data;
   entry_type       req_entry;
   result_type      res;
   logic            res_valid;
   ctrl_status_type ctrl_st;
   logic            out_free;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [71:0]     rsp_data_ff, rsp_data_in;
   logic [3:0]      rsp_user_ff, rsp_user_in;

   assign req_entry.seq = req_tdata[31:0];
   assign req_entry.tag = req_tdata[63:32];

   assign out_free = !rsp_valid_ff || rsp_tready;

   srob_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_action (req_tuser),
      .req_entry  (req_entry),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .mem_req    (mem_req),
      .rd_data    (rd_data),
      .out_free   (out_free),
      .res_valid  (res_valid),
      .res        (res),
      .st         (ctrl_st)
   );

   srob_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {res.is_empty, res.is_full, res.occupancy,
                         res.out_tag, res.out_seq};
         rsp_user_in  = {res.out_valid, res.status};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // checks
   `CHK_ASSERT(a_busy_after_req, req_tvalid && req_tready |=> !ctrl_st.idle, "idle after request")
   `CHK_NEVER(a_count_in_cap, ctrl_st.count > ctrl_st.cap, "occupancy above capacity")
   `CHK_ASSERT(a_entry_ok, rsp_tvalid && rsp_tuser[3] |-> rsp_tuser[2:0] == ST_OK, "entry with bad status")
   `CHK_ASSERT(a_no_entry_zero, rsp_tvalid && !rsp_tuser[3] |-> rsp_tdata[63:0] == '0, "stale entry data")

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import srob_pkg::*;

   // action codes the block leaves unused
   localparam logic [2:0] ACT_SPARE_6 = 3'd6;
   localparam logic [2:0] ACT_SPARE_7 = 3'd7;

   localparam int PHASE_ITEMS = 108;
   localparam int IDLE_MAX    = 19;

   typedef enum logic {ROW_REQ, ROW_CAP} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [2:0]   action;
      logic [31:0]  seq;
      logic [31:0]  tag;
      logic [5:0]   cap_value;
      bit           typed;
      result_type   want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [5:0]  csr_data;

   // predicted deque contents and pointers
   logic [31:0] key_mem [DEPTH];
   logic [31:0] tag_mem [DEPTH];
   int          front_idx;
   int          back_idx;
   int          held;
   logic [5:0]  cap_reg;

   result_type   pending_results [$];
   stim_row_type dir_table [$];
   int           mismatch_count;
   bit           req_idle_on;
   bit           rsp_idle_on;

   sorted_deque_reorder_buffer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // capacity actually used by the ring
   function automatic int cap_eff();
      if (cap_reg == 6'd0) return 1;
      if (int'(cap_reg) > DEPTH) return DEPTH;
      return int'(cap_reg);
   endfunction

   function automatic int ring_next(int i, int cap);
      return (i + 1 >= cap) ? 0 : i + 1;
   endfunction

   function automatic int ring_prev(int i, int cap);
      return (i == 0 || i >= cap) ? cap - 1 : i - 1;
   endfunction

   // deque behavior for one request; updates the predicted state
   function automatic result_type deque_outcome(logic [2:0] act, logic [31:0] key,
                                                logic [31:0] tg);
      result_type r;
      int cap, cur, nxt, p, i;
      bit hit, stop;
      cap = cap_eff();
      r = '0;
      case (act)
         ACT_PUSH_BACK: begin
            if (held >= cap) begin
               front_idx = ring_next(front_idx, cap);
               held--;
               r.status = ST_DROPPED;
            end
            key_mem[back_idx] = key;
            tag_mem[back_idx] = tg;
            back_idx = ring_next(back_idx, cap);
            held++;
         end
         ACT_PUSH_FRONT: begin
            if (held >= cap) begin
               back_idx = ring_prev(back_idx, cap);
               held--;
               r.status = ST_DROPPED;
            end
            front_idx = ring_prev(front_idx, cap);
            key_mem[front_idx] = key;
            tag_mem[front_idx] = tg;
            held++;
         end
         ACT_INSERT: begin
            if (held >= cap) begin
               r.status = ST_FULL;
            end else begin
               hit = 1'b0;
               p = front_idx;
               for (i = 0; i < held; i++) begin
                  if (key_mem[p] == key) hit = 1'b1;
                  p = ring_next(p, cap);
               end
               if (hit) begin
                  r.status = ST_DUP;
               end else begin
                  // lower keys slide one slot toward the front
                  front_idx = ring_prev(front_idx, cap);
                  cur = front_idx;
                  stop = 1'b0;
                  for (i = 0; i < held; i++) begin
                     nxt = ring_next(cur, cap);
                     if (!stop && key_mem[nxt] > key) stop = 1'b1;
                     if (!stop) begin
                        key_mem[cur] = key_mem[nxt];
                        tag_mem[cur] = tag_mem[nxt];
                        cur = nxt;
                     end
                  end
                  key_mem[cur] = key;
                  tag_mem[cur] = tg;
                  held++;
               end
            end
         end
         ACT_POP, ACT_PEEK: begin
            if (held == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.out_valid = 1'b1;
               r.out_seq = key_mem[front_idx];
               r.out_tag = tag_mem[front_idx];
               if (act == ACT_POP) begin
                  front_idx = ring_next(front_idx, cap);
                  held--;
               end
            end
         end
         ACT_CLEAR: begin
            front_idx = 0;
            back_idx = 0;
            held = 0;
         end
         default: ;
      endcase
      r.occupancy = held[5:0];
      r.is_full = (held == cap);
      r.is_empty = (held == 0);
      return r;
   endfunction

   function automatic result_type mk_result(logic [2:0] st, logic vld, logic [31:0] oseq,
                                            logic [31:0] otag, int occ, logic full,
                                            logic empty);
      result_type r;
      r.status = st;
      r.out_valid = vld;
      r.out_seq = oseq;
      r.out_tag = otag;
      r.occupancy = occ[5:0];
      r.is_full = full;
      r.is_empty = empty;
      return r;
   endfunction

   function automatic stim_row_type req_row(logic [2:0] act, logic [31:0] key,
                                            logic [31:0] tg);
      stim_row_type s;
      s.kind = ROW_REQ;
      s.action = act;
      s.seq = key;
      s.tag = tg;
      s.cap_value = '0;
      s.typed = 1'b0;
      s.want = '0;
      return s;
   endfunction

   function automatic stim_row_type typed_row(logic [2:0] act, logic [31:0] key,
                                              logic [31:0] tg, result_type want);
      stim_row_type s;
      s = req_row(act, key, tg);
      s.typed = 1'b1;
      s.want = want;
      return s;
   endfunction

   function automatic stim_row_type cap_row(logic [5:0] v);
      stim_row_type s;
      s = req_row(ACT_CLEAR, '0, '0);
      s.kind = ROW_CAP;
      s.cap_value = v;
      return s;
   endfunction

   // random action, weighted toward growth or toward draining
   function automatic logic [2:0] pick_action(bit grow);
      int r;
      r = $urandom_range(0, 99);
      if (grow) begin
         if (r < 30) return ACT_PUSH_BACK;
         if (r < 50) return ACT_PUSH_FRONT;
         if (r < 85) return ACT_INSERT;
         if (r < 93) return ACT_POP;
         if (r < 98) return ACT_PEEK;
         if (r < 99) return ACT_CLEAR;
         return ($urandom_range(0, 1) != 0) ? ACT_SPARE_6 : ACT_SPARE_7;
      end
      if (r < 12) return ACT_PUSH_BACK;
      if (r < 20) return ACT_PUSH_FRONT;
      if (r < 45) return ACT_INSERT;
      if (r < 80) return ACT_POP;
      if (r < 95) return ACT_PEEK;
      if (r < 98) return ACT_CLEAR;
      return ($urandom_range(0, 1) != 0) ? ACT_SPARE_6 : ACT_SPARE_7;
   endfunction

   // key source: held keys for duplicates, extremes, a narrow pool, or anything
   function automatic logic [31:0] pick_key();
      int r, k, p;
      r = $urandom_range(0, 9);
      if (r < 2 && held > 0) begin
         k = $urandom_range(0, held - 1);
         p = front_idx;
         repeat (k) p = ring_next(p, cap_eff());
         return key_mem[p];
      end
      if (r < 3) begin
         case ($urandom_range(0, 3))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            default: return 32'h7FFF_FFFF;
         endcase
      end
      if (r < 6) return $urandom_range(0, 63);
      return $urandom;
   endfunction

   // stop issuing requests and wait for every result to come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(logic [5:0] v);
      drain_results();
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cap_reg = v;
      front_idx = 0;
      back_idx = 0;
      held = 0;
   endtask

   // one request; valid stays high after acceptance when the next gap is zero
   task automatic send_request(logic [2:0] act, logic [31:0] key, logic [31:0] tg,
                               bit typed, result_type want);
      result_type predicted;
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= {tg, key};
      req_tuser <= act;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = deque_outcome(act, key, tg);
      pending_results.push_back(typed ? want : predicted);
      gap = req_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic report_mismatch(string what, result_type want, result_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t %s: exp st=%0d v=%0d seq=%h tag=%h occ=%0d full=%0d empty=%0d",
                  $realtime, what, want.status, want.out_valid, want.out_seq, want.out_tag,
                  want.occupancy, want.is_full, want.is_empty);
         $display("%0t %s: got st=%0d v=%0d seq=%h tag=%h occ=%0d full=%0d empty=%0d",
                  $realtime, what, got.status, got.out_valid, got.out_seq, got.out_tag,
                  got.occupancy, got.is_full, got.is_empty);
      end
   endtask

   // result side: random stalls, compare each result with the oldest prediction
   initial begin
      result_type got;
      result_type want;
      int stall;
      rsp_tready <= 1'b0;
      rsp_idle_on = 1'b1;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if ($urandom_range(0, 29) == 0) rsp_idle_on = ~rsp_idle_on;
         stall = rsp_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         got.status = rsp_tuser[2:0];
         got.out_valid = rsp_tuser[3];
         got.out_seq = rsp_tdata[31:0];
         got.out_tag = rsp_tdata[63:32];
         got.occupancy = rsp_tdata[69:64];
         got.is_full = rsp_tdata[70];
         got.is_empty = rsp_tdata[71];
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", '0, got);
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status || got.out_valid !== want.out_valid ||
                got.out_seq !== want.out_seq || got.out_tag !== want.out_tag ||
                got.occupancy !== want.occupancy || got.is_full !== want.is_full ||
                got.is_empty !== want.is_empty)
               report_mismatch("result mismatch", want, got);
         end
      end
   end

   // run limit
   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // stimulus
   initial begin
      int ph, n;
      bit grow;
      logic [5:0] phase_cap [6];
      logic [2:0] act;
      logic [31:0] tg;

      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= ACT_PUSH_BACK;
      csr_valid <= 1'b0;
      csr_data <= '0;
      mismatch_count = 0;
      req_idle_on = 1'b1;
      cap_reg = CAP_RESET;
      front_idx = 0;
      back_idx = 0;
      held = 0;
      for (int i = 0; i < DEPTH; i++) begin
         key_mem[i] = '0;
         tag_mem[i] = '0;
      end

      // directed table, capacity at its reset value first
      dir_table.push_back(typed_row(ACT_POP, 32'h0, 32'h0,
                                    mk_result(ST_EMPTY, 0, 0, 0, 0, 0, 1)));
      dir_table.push_back(typed_row(ACT_PEEK, 32'h0, 32'h0,
                                    mk_result(ST_EMPTY, 0, 0, 0, 0, 0, 1)));
      dir_table.push_back(typed_row(ACT_PUSH_BACK, 32'h0, 32'h0,
                                    mk_result(ST_OK, 0, 0, 0, 1, 0, 0)));
      dir_table.push_back(typed_row(ACT_PUSH_BACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                    mk_result(ST_OK, 0, 0, 0, 2, 0, 0)));
      dir_table.push_back(typed_row(ACT_PUSH_FRONT, 32'h5, 32'hA5A5_A5A5,
                                    mk_result(ST_OK, 0, 0, 0, 3, 0, 0)));
      dir_table.push_back(typed_row(ACT_PEEK, 32'h0, 32'h0,
                                    mk_result(ST_OK, 1, 32'h5, 32'hA5A5_A5A5, 3, 0, 0)));
      // duplicate keys at both extremes
      dir_table.push_back(typed_row(ACT_INSERT, 32'h0, 32'h1,
                                    mk_result(ST_DUP, 0, 0, 0, 3, 0, 0)));
      dir_table.push_back(typed_row(ACT_INSERT, 32'hFFFF_FFFF, 32'h2,
                                    mk_result(ST_DUP, 0, 0, 0, 3, 0, 0)));
      dir_table.push_back(req_row(ACT_INSERT, 32'h7, 32'h5A5A_5A5A));
      dir_table.push_back(req_row(ACT_INSERT, 32'h3, 32'h0F0F_0F0F));
      // unused action codes
      dir_table.push_back(req_row(ACT_SPARE_6, 32'h1234_5678, 32'h9ABC_DEF0));
      dir_table.push_back(req_row(ACT_SPARE_7, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      dir_table.push_back(req_row(ACT_POP, 32'h0, 32'h0));
      dir_table.push_back(req_row(ACT_PEEK, 32'h0, 32'h0));
      dir_table.push_back(typed_row(ACT_CLEAR, 32'h0, 32'h0,
                                    mk_result(ST_OK, 0, 0, 0, 0, 0, 1)));
      dir_table.push_back(typed_row(ACT_POP, 32'h0, 32'h0,
                                    mk_result(ST_EMPTY, 0, 0, 0, 0, 0, 1)));
      // single slot: drops at either end and a refused insert
      dir_table.push_back(cap_row(6'd1));
      dir_table.push_back(typed_row(ACT_PUSH_BACK, 32'h1, 32'h11,
                                    mk_result(ST_OK, 0, 0, 0, 1, 1, 0)));
      dir_table.push_back(typed_row(ACT_PUSH_BACK, 32'h2, 32'h22,
                                    mk_result(ST_DROPPED, 0, 0, 0, 1, 1, 0)));
      dir_table.push_back(typed_row(ACT_PUSH_FRONT, 32'h3, 32'h33,
                                    mk_result(ST_DROPPED, 0, 0, 0, 1, 1, 0)));
      dir_table.push_back(typed_row(ACT_INSERT, 32'h9, 32'h99,
                                    mk_result(ST_FULL, 0, 0, 0, 1, 1, 0)));
      dir_table.push_back(req_row(ACT_POP, 32'h0, 32'h0));
      dir_table.push_back(req_row(ACT_INSERT, 32'h4, 32'h44));
      // zero capacity behaves as one
      dir_table.push_back(cap_row(6'd0));
      dir_table.push_back(req_row(ACT_PUSH_BACK, 32'hFFFF_FFFF, 32'h0));
      dir_table.push_back(req_row(ACT_PUSH_BACK, 32'h0, 32'hFFFF_FFFF));
      // oversized capacity clips to depth; the write empties the queue
      dir_table.push_back(cap_row(6'd63));
      dir_table.push_back(typed_row(ACT_PEEK, 32'h0, 32'h0,
                                    mk_result(ST_EMPTY, 0, 0, 0, 0, 0, 1)));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[i]) begin
         if (dir_table[i].kind == ROW_CAP)
            write_capacity(dir_table[i].cap_value);
         else
            send_request(dir_table[i].action, dir_table[i].seq, dir_table[i].tag,
                         dir_table[i].typed, dir_table[i].want);
      end

      // random phases over a spread of capacities
      phase_cap[0] = 6'd3;
      phase_cap[1] = 6'd32;
      phase_cap[2] = 6'd1;
      phase_cap[3] = 6'd7;
      phase_cap[4] = 6'($urandom_range(0, 63));
      phase_cap[5] = 6'($urandom_range(1, 32));
      grow = 1'b1;
      for (ph = 0; ph < 6; ph++) begin
         write_capacity(phase_cap[ph]);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 40 == 0) grow = ($urandom_range(0, 2) != 0);
            if (n % 60 == 0) req_idle_on = ($urandom_range(0, 3) != 0);
            // hold off until the pipeline is empty once mid-run
            if (ph == 2 && n == 50) drain_results();
            act = pick_action(grow);
            tg = ($urandom_range(0, 9) == 0) ? {32{$urandom_range(0, 1) == 1}} : $urandom;
            send_request(act, pick_key(), tg, 1'b0, '0);
         end
      end

      drain_results();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
